// ----- rtl/sm64rd_pkg.sv -----
// shared constants and command codes for the splitmix64 random draw block
// no dependencies; used by the top level and the arithmetic units
`default_nettype none

package sm64rd_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = WORD_W / 2;

    // command codes of an input word
    localparam logic [1:0] CMD_ABSORB = 2'd0;
    localparam logic [1:0] CMD_MASKED = 2'd1;
    localparam logic [1:0] CMD_RANGE  = 2'd2;

    // generator constants
    localparam logic [WORD_W-1:0] GOLDEN_STEP   = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A     = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B     = 64'h94d049bb133111eb;
    localparam logic [WORD_W-1:0] FALLBACK_SEED = 64'h00006b6167757261;
    localparam logic [WORD_W-1:0] FNV_BASIS     = 64'hcbf29ce484222325;
    localparam logic [WORD_W-1:0] FNV_MULT      = 64'h00000100000001b3;

endpackage

`default_nettype wire

// ----- rtl/splitmix64_seeded_random_draw.sv -----
// top level of the splitmix64 random draw block with build-id seed mixing
// uses sm64rd_pkg, sm64rd_mul (shared multiplier) and sm64rd_div (modulo unit)
`default_nettype none

// One input word at a time: o_in_stall stays high from the accepting edge until a
// draw's result has been loaded into the output register or a byte's hash updated.
// A build-id byte (cmd 0) is folded into the hash through the shared multiplier.
// A masked draw (cmd 1) runs seeding, one add and two finalizer products through
// the same multiplier. A range draw (cmd 2) adds the bit-serial modulo unit; an
// empty range skips the add and products and returns zero with the range error.
// The output register holds one result, so the next word is taken while that
// result still waits on i_out_stall. cmd 3 is taken and dropped.
// The seed register may be written through the config port whenever the block is idle.
module splitmix64_seeded_random_draw (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // config write
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [63:0]  i_cfg_data,
    // input words
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic [1:0]   i_cmd,
    input  wire logic [7:0]   i_build_byte,
    input  wire logic [6:0]   i_draw_width,
    input  wire logic [63:0]  i_range_low,
    input  wire logic [63:0]  i_range_high,
    // result words
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic [63:0]       o_draw_value,
    output logic              o_range_error
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_ADV,
        ST_MIX_A,
        ST_WAIT_A,
        ST_MIX_B,
        ST_WAIT_B,
        ST_FIN,
        ST_WAIT_D,
        ST_OUT
    } t_state;

    t_state       r_state;
    logic [63:0]  r_base_seed;
    logic [63:0]  r_gen;
    logic         r_seeded;
    logic [63:0]  r_hash;
    logic         r_seen;
    logic [1:0]   r_cmd;
    logic [6:0]   r_width;
    logic [63:0]  r_lo;
    logic [63:0]  r_hi;
    logic [63:0]  r_span;
    logic [63:0]  r_res_value;
    logic         r_res_error;
    logic         r_out_valid;
    logic [63:0]  r_out_value;
    logic         r_out_error;

    logic         in_accept;
    logic [63:0]  seed_mix;
    logic [63:0]  seed_val;
    logic         mul_start;
    logic [63:0]  mul_a;
    logic [63:0]  mul_b;
    logic         mul_done;
    logic [63:0]  mul_p;
    logic         div_start;
    logic         div_done;
    logic [63:0]  div_rem;
    logic [63:0]  fin_z;
    logic [63:0]  width_mask;

    assign in_accept   = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // seed from base seed and build-id hash, zero falls back to default
    always_comb begin
        seed_mix = r_base_seed ^ (r_seen ? r_hash : 64'd0);
        seed_val = (seed_mix == 64'd0) ? sm64rd_pkg::FALLBACK_SEED : seed_mix;
    end

    // finalizer tail and draw width mask
    always_comb begin
        fin_z = mul_p ^ (mul_p >> 31);
        if (r_width[6]) begin
            width_mask = '1;
        end else begin
            width_mask = ~({64{1'b1}} << r_width[5:0]);
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_start = 1'b0;
        mul_a     = r_gen ^ (r_gen >> 30);
        mul_b     = sm64rd_pkg::MIX_MUL_A;
        case (r_state)
            ST_IDLE: begin
                mul_start = in_accept && (i_cmd == sm64rd_pkg::CMD_ABSORB);
                mul_a     = r_hash ^ {56'd0, i_build_byte};
                mul_b     = sm64rd_pkg::FNV_MULT;
            end
            ST_MIX_A: begin
                mul_start = 1'b1;
            end
            ST_MIX_B: begin
                mul_start = 1'b1;
                mul_a     = mul_p ^ (mul_p >> 27);
                mul_b     = sm64rd_pkg::MIX_MUL_B;
            end
            default: ;
        endcase
    end

    assign div_start = (r_state == ST_FIN) && (r_cmd == sm64rd_pkg::CMD_RANGE);

    sm64rd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    sm64rd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (fin_z),
        .i_den   (r_span),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    // sequencer, generator state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_base_seed <= '0;
            r_gen       <= '0;
            r_seeded    <= 1'b0;
            r_hash      <= sm64rd_pkg::FNV_BASIS;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_base_seed <= i_cfg_data;
            end
            // output word loaded, or taken by the receiver
            if ((r_state == ST_OUT) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_cmd   <= i_cmd;
                        r_width <= i_draw_width;
                        r_lo    <= i_range_low;
                        r_hi    <= i_range_high;
                        case (i_cmd)
                            sm64rd_pkg::CMD_ABSORB: begin
                                r_seen  <= 1'b1;
                                r_state <= ST_HASH;
                            end
                            sm64rd_pkg::CMD_MASKED, sm64rd_pkg::CMD_RANGE: begin
                                if (!r_seeded) begin
                                    r_gen    <= seed_val;
                                    r_seeded <= 1'b1;
                                end
                                r_state <= ST_ADV;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_HASH: begin
                    if (mul_done) begin
                        r_hash  <= mul_p;
                        r_state <= ST_IDLE;
                    end
                end
                ST_ADV: begin
                    if (r_cmd == sm64rd_pkg::CMD_RANGE && r_hi <= r_lo) begin
                        r_res_value <= '0;
                        r_res_error <= 1'b1;
                        r_state     <= ST_OUT;
                    end else begin
                        r_gen   <= r_gen + sm64rd_pkg::GOLDEN_STEP;
                        r_span  <= r_hi - r_lo;
                        r_state <= ST_MIX_A;
                    end
                end
                ST_MIX_A: r_state <= ST_WAIT_A;
                ST_WAIT_A: begin
                    if (mul_done) begin
                        r_state <= ST_MIX_B;
                    end
                end
                ST_MIX_B: r_state <= ST_WAIT_B;
                ST_WAIT_B: begin
                    if (mul_done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (r_cmd == sm64rd_pkg::CMD_RANGE) begin
                        r_state <= ST_WAIT_D;
                    end else begin
                        r_res_value <= fin_z & width_mask;
                        r_res_error <= 1'b0;
                        r_state     <= ST_OUT;
                    end
                end
                ST_WAIT_D: begin
                    if (div_done) begin
                        r_res_value <= r_lo + div_rem;
                        r_res_error <= 1'b0;
                        r_state     <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_value <= r_res_value;
                        r_out_error <= r_res_error;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_draw_value  = r_out_value;
    assign o_range_error = r_out_error;

endmodule

`default_nettype wire

// ----- rtl/sm64rd_mul.sv -----
// iterative 64x64 multiplier keeping the low 64 bits of the product
// one 32x32 multiplier reused for each partial product; uses sm64rd_pkg
`default_nettype none

module sm64rd_mul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [sm64rd_pkg::WORD_W-1:0] i_a,
    input  wire logic [sm64rd_pkg::WORD_W-1:0] i_b,
    output logic                               o_done,
    output logic [sm64rd_pkg::WORD_W-1:0]      o_p
);

    logic [sm64rd_pkg::WORD_W-1:0] r_a;
    logic [sm64rd_pkg::WORD_W-1:0] r_b;
    logic [sm64rd_pkg::WORD_W-1:0] r_prod;
    logic [sm64rd_pkg::WORD_W-1:0] r_acc;
    logic [1:0]                    r_step;
    logic                          r_busy;
    logic                          r_done;
    logic [sm64rd_pkg::HALF_W-1:0] op_x;
    logic [sm64rd_pkg::HALF_W-1:0] op_y;

    // partial product select: lo*lo, lo*hi, hi*lo
    always_comb begin
        case (r_step)
            2'd0: begin
                op_x = r_a[sm64rd_pkg::HALF_W-1:0];
                op_y = r_b[sm64rd_pkg::HALF_W-1:0];
            end
            2'd1: begin
                op_x = r_a[sm64rd_pkg::HALF_W-1:0];
                op_y = r_b[sm64rd_pkg::WORD_W-1:sm64rd_pkg::HALF_W];
            end
            default: begin
                op_x = r_a[sm64rd_pkg::WORD_W-1:sm64rd_pkg::HALF_W];
                op_y = r_b[sm64rd_pkg::HALF_W-1:0];
            end
        endcase
    end

    // product register, then accumulate on the following cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= !i_start && r_busy && (r_step == 2'd3);
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_step <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_prod <= op_x * op_y;
                r_step <= r_step + 2'd1;
                case (r_step)
                    2'd0: ;
                    2'd1: r_acc <= r_prod;
                    default: r_acc <= r_acc
                        + {r_prod[sm64rd_pkg::HALF_W-1:0], {sm64rd_pkg::HALF_W{1'b0}}};
                endcase
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

`default_nettype wire

// ----- rtl/sm64rd_div.sv -----
// iterative 64-bit restoring modulo, one quotient bit per cycle
// uses sm64rd_pkg
`default_nettype none

module sm64rd_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [sm64rd_pkg::WORD_W-1:0] i_num,
    input  wire logic [sm64rd_pkg::WORD_W-1:0] i_den,
    output logic                               o_done,
    output logic [sm64rd_pkg::WORD_W-1:0]      o_rem
);

    logic [sm64rd_pkg::WORD_W-1:0] r_num;
    logic [sm64rd_pkg::WORD_W-1:0] r_den;
    logic [sm64rd_pkg::WORD_W-1:0] r_rem;
    logic [5:0]                    r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [sm64rd_pkg::WORD_W:0]   trial;
    logic [sm64rd_pkg::WORD_W:0]   diff;

    // shift in next dividend bit and try the subtract
    always_comb begin
        trial = {r_rem, r_num[sm64rd_pkg::WORD_W-1]};
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == 6'd63);
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[sm64rd_pkg::WORD_W-2:0], 1'b0};
                if (!diff[sm64rd_pkg::WORD_W]) begin
                    r_rem <= diff[sm64rd_pkg::WORD_W-1:0];
                end else begin
                    r_rem <= trial[sm64rd_pkg::WORD_W-1:0];
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// testbench for splitmix64_seeded_random_draw: directed table, then random words
// checked against an in-bench splitmix64 / fnv-1a model; needs sm64rd_pkg and the rtl
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [63:0] ALL_ONES    = 64'hffff_ffff_ffff_ffff;
    localparam int          DIR_ROWS    = 21;
    localparam int          PHASES      = 6;
    localparam int          PHASE_WORDS = 200;
    localparam int          SETTLE      = 100;
    localparam int          HOLD_CYCLES = 400;
    localparam int          LIMIT       = 800000;

    // one input word plus an optional typed-in expectation
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  build_byte;
        logic [6:0]  width;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        known;
        logic [63:0] kval;
        logic        kerr;
    } t_draw_row;

    typedef struct packed {
        logic [63:0] value;
        logic        err;
    } t_draw_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    t_draw_row   cur_row;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [63:0] o_draw_value;
    logic        o_range_error;

    splitmix64_seeded_random_draw DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (cur_row.cmd),
        .i_build_byte (cur_row.build_byte),
        .i_draw_width (cur_row.width),
        .i_range_low  (cur_row.lo),
        .i_range_high (cur_row.hi),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_draw_value (o_draw_value),
        .o_range_error(o_range_error)
    );

    // model state, reset values
    logic [63:0]  seed_reg   = '0;
    logic [63:0]  gen_state  = '0;
    logic         gen_seeded = 1'b0;
    logic [63:0]  id_hash    = sm64rd_pkg::FNV_BASIS;
    logic         id_seen    = 1'b0;
    t_draw_result pending_draws[$];

    int  mismatches = 0;
    int  cycles     = 0;
    bit  no_idle    = 1'b0;
    bit  hold_req   = 1'b0;

    t_draw_row dir_tab [DIR_ROWS];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL splitmix64_seeded_random_draw");
            $finish;
        end
    end

    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * sm64rd_pkg::FNV_MULT;
    endfunction

    // seed once on the first draw, xor in the build-id hash if any byte came
    function automatic void seed_generator();
        logic [63:0] s;
        if (!gen_seeded) begin
            s = seed_reg;
            if (id_seen)
                s = s ^ id_hash;
            gen_state  = (s != '0) ? s : sm64rd_pkg::FALLBACK_SEED;
            gen_seeded = 1'b1;
        end
    endfunction

    // golden-ratio step and splitmix64 finalizer
    function automatic logic [63:0] next_draw();
        logic [63:0] z;
        gen_state = gen_state + sm64rd_pkg::GOLDEN_STEP;
        z = gen_state;
        z = (z ^ (z >> 30)) * sm64rd_pkg::MIX_MUL_A;
        z = (z ^ (z >> 27)) * sm64rd_pkg::MIX_MUL_B;
        return z ^ (z >> 31);
    endfunction

    // expected result of one accepted word
    task automatic predict_draw(input t_draw_row w);
        t_draw_result r;
        r.value = '0;
        r.err   = 1'b0;
        case (w.cmd)
            sm64rd_pkg::CMD_ABSORB: begin
                id_hash = fnv_fold(id_hash, w.build_byte);
                id_seen = 1'b1;
            end
            sm64rd_pkg::CMD_MASKED: begin
                seed_generator();
                r.value = next_draw();
                if (w.width < 7'd64)
                    r.value = r.value & ((64'd1 << w.width) - 64'd1);
            end
            sm64rd_pkg::CMD_RANGE: begin
                seed_generator();
                if (w.hi <= w.lo)
                    r.err = 1'b1;
                else
                    r.value = w.lo + (next_draw() % (w.hi - w.lo));
            end
            default: ;
        endcase
        if (w.cmd == sm64rd_pkg::CMD_MASKED || w.cmd == sm64rd_pkg::CMD_RANGE) begin
            if (w.known) begin
                r.value = w.kval;
                r.err   = w.kerr;
            end
            pending_draws.insert(pending_draws.size(), r);
        end
    endtask

    // monitors: config writes, accepted input words, accepted result words
    always @(posedge i_clk) begin
        t_draw_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                seed_reg = i_cfg_data;
            if (o_out_valid && !i_out_stall) begin
                if (pending_draws.size() == 0) begin
                    $error("unexpected result word: draw_value %h range_error %b",
                           o_draw_value, o_range_error);
                    mismatches++;
                end else begin
                    want = pending_draws.pop_front();
                    if (o_draw_value !== want.value) begin
                        $error("draw_value: expected %h, got %h", want.value, o_draw_value);
                        mismatches++;
                    end
                    if (o_range_error !== want.err) begin
                        $error("range_error: expected %b, got %b", want.err, o_range_error);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall)
                predict_draw(cur_row);
        end
    end

    // result side: random stall per word, early or after the word shows up
    initial begin
        int k;
        bit late;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            k    = no_idle ? 0 : $urandom_range(0, 3);
            late = 1'($urandom_range(0, 1));
            if (hold_req) begin
                k        = HOLD_CYCLES;
                late     = 1'b0;
                hold_req = 1'b0;
            end
            if (k != 0) begin
                i_out_stall <= 1'b1;
                if (late) begin
                    do @(posedge i_clk); while (!o_out_valid);
                end
                repeat (k) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // offer one word after a random gap, return once accepted
    task automatic put_word(input t_draw_row w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        cur_row    <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop sending, wait for every result, then let an absorb finish
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // random word: mostly draws, some absorbs and unused commands
    function automatic t_draw_row random_row();
        t_draw_row w;
        logic [63:0] t;
        int pick;
        w.cmd        = sm64rd_pkg::CMD_MASKED;
        w.build_byte = 8'($urandom_range(0, 255));
        w.width      = 7'($urandom_range(0, 127));
        w.lo         = rand64();
        w.hi         = rand64();
        w.known      = 1'b0;
        w.kval       = '0;
        w.kerr       = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            w.cmd = sm64rd_pkg::CMD_ABSORB;
        end else if (pick < 11) begin
            w.cmd = CMD_UNUSED;
        end else if (pick < 55) begin
            if ($urandom_range(0, 3) != 0)
                w.width = 7'($urandom_range(0, 64));
        end else begin
            w.cmd = sm64rd_pkg::CMD_RANGE;
            pick  = $urandom_range(0, 9);
            if (pick == 0) begin
                w.hi = w.lo;
            end else if (pick < 6) begin
                // small span that cannot wrap
                w.lo = w.lo >> $urandom_range(1, 63);
                w.hi = w.lo + 64'($urandom_range(1, 1000));
            end
            // empty range when pick is 0 or 1, otherwise high above low
            if ((pick == 1) != (w.hi <= w.lo)) begin
                t    = w.lo;
                w.lo = w.hi;
                w.hi = t;
            end
        end
        return w;
    endfunction

    // stimulus
    initial begin
        logic [63:0] pre_hash;
        logic [63:0] first_seed;
        int n;

        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        cur_row     = '0;

        // bytes, unused command, masked widths, empty and narrow ranges, late byte
        dir_tab = '{
            '{sm64rd_pkg::CMD_ABSORB, 8'h00, 7'd0, 64'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{sm64rd_pkg::CMD_ABSORB, 8'hff, 7'd0, 64'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{sm64rd_pkg::CMD_ABSORB, 8'ha5, 7'd0, 64'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{CMD_UNUSED, 8'hff, 7'd127, ALL_ONES, ALL_ONES, 1'b0, 64'd0, 1'b0},
            '{sm64rd_pkg::CMD_MASKED, 8'h00, 7'd0,   64'd0, 64'd0, 1'b1, 64'd0, 1'b0},
            '{sm64rd_pkg::CMD_MASKED, 8'h00, 7'd64,  64'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{sm64rd_pkg::CMD_MASKED, 8'h00, 7'd1,   64'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{sm64rd_pkg::CMD_MASKED, 8'h00, 7'd63,  64'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{sm64rd_pkg::CMD_MASKED, 8'h00, 7'd127, 64'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{sm64rd_pkg::CMD_MASKED, 8'h00, 7'd65,  64'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{sm64rd_pkg::CMD_RANGE, 8'h00, 7'd0, 64'd5, 64'd5, 1'b1, 64'd0, 1'b1},
            '{sm64rd_pkg::CMD_RANGE, 8'h00, 7'd0, ALL_ONES, 64'd0, 1'b1, 64'd0, 1'b1},
            '{sm64rd_pkg::CMD_RANGE, 8'h00, 7'd0, 64'd0, ALL_ONES, 1'b0, 64'd0, 1'b0},
            '{sm64rd_pkg::CMD_RANGE, 8'h00, 7'd0, ALL_ONES - 1, ALL_ONES,
              1'b1, ALL_ONES - 1, 1'b0},
            '{sm64rd_pkg::CMD_RANGE, 8'h00, 7'd0, 64'd0, 64'd1, 1'b1, 64'd0, 1'b0},
            '{sm64rd_pkg::CMD_RANGE, 8'h00, 7'd0, 64'd100, 64'd107, 1'b0, 64'd0, 1'b0},
            '{sm64rd_pkg::CMD_RANGE, 8'h00, 7'd0, 64'd0, 64'h8000_0000_0000_0000,
              1'b0, 64'd0, 1'b0},
            '{sm64rd_pkg::CMD_ABSORB, 8'h3c, 7'd0,  64'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{sm64rd_pkg::CMD_MASKED, 8'h00, 7'd32, 64'd0, 64'd0, 1'b0, 64'd0, 1'b0},
            '{sm64rd_pkg::CMD_RANGE, 8'h00, 7'd0, 64'd1, ALL_ONES, 1'b0, 64'd0, 1'b0},
            '{sm64rd_pkg::CMD_MASKED, 8'h00, 7'd7,  64'd0, 64'd0, 1'b0, 64'd0, 1'b0}
        };

        // reset
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // hash of the bytes ahead of the first draw
        pre_hash = sm64rd_pkg::FNV_BASIS;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].cmd == sm64rd_pkg::CMD_MASKED ||
                dir_tab[i].cmd == sm64rd_pkg::CMD_RANGE)
                break;
            if (dir_tab[i].cmd == sm64rd_pkg::CMD_ABSORB)
                pre_hash = fnv_fold(pre_hash, dir_tab[i].build_byte);
        end

        // seed cancelling the hash falls back to the default; else plain hash or mixed
        case ($urandom_range(0, 2))
            0:       first_seed = pre_hash;
            1:       first_seed = '0;
            default: first_seed = rand64();
        endcase
        cfg_write(ALL_ONES);
        cfg_write('0);
        cfg_write(first_seed);

        foreach (dir_tab[i])
            put_word(dir_tab[i]);
        drain();

        // random phases, late seed write between them
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       cfg_write(ALL_ONES);
                1:       cfg_write('0);
                default: cfg_write(rand64());
            endcase
            no_idle = (p == 3);
            if (p == 1)
                hold_req = 1'b1;
            n = 0;
            while (n < PHASE_WORDS) begin
                t_draw_row w;
                w = random_row();
                put_word(w);
                if (w.cmd != CMD_UNUSED)
                    n++;
            end
            drain();
        end

        if (mismatches == 0)
            $display("PASS splitmix64_seeded_random_draw");
        else
            $display("FAIL splitmix64_seeded_random_draw");
        $finish;
    end

endmodule

`default_nettype wire
